// ===== hw/rtl/mgdg_pkg.sv =====
// shared constants, codes and types for the mackey-glass delay generator
// no dependencies
package mgdg_pkg;

    localparam int RING_DEPTH = 512;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int LEN_W      = RING_AW + 1;
    localparam int MAX_TAPS   = 15;
    localparam int TAP_W      = 4;
    localparam int SAMPLE_W   = 32;
    localparam int FRAC_BITS  = 24;
    localparam int COEF_W     = 16;
    localparam int CFG_IDX_W  = 3;

    localparam int MUL_OP_W   = 40;
    localparam int MUL_HALF_W = MUL_OP_W / 2;
    localparam int MUL_PROD_W = 2 * MUL_OP_W;
    localparam int POW_W      = 56;
    localparam int DIV_NUM_W  = 56;
    localparam int DIV_DEN_W  = 57;
    localparam int DIV_STEP_W = 6;

    localparam logic [POW_W-1:0] POW_CAP = POW_W'(1) << 55;

    localparam logic [1:0] MODE_STORE = 2'd0;
    localparam logic [1:0] MODE_STEP  = 2'd1;
    localparam logic [1:0] MODE_EMIT  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RING_LEN  = 3'd5;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_ctl_t;

endpackage

// ===== hw/rtl/mgdg_mul.sv =====
// shared 40x40 multiplier built from a 40x20 array, low half of y first, then high half
// depends on mgdg_pkg
module mgdg_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [mgdg_pkg::MUL_OP_W-1:0]   x,
    input  logic [mgdg_pkg::MUL_OP_W-1:0]   y,
    output logic [mgdg_pkg::MUL_PROD_W-1:0] prod,
    output logic                            done
);
    import mgdg_pkg::*;

    logic                          busy_reg;
    logic                          phase_reg;
    logic                          done_reg;
    logic [MUL_OP_W-1:0]           x_reg;
    logic [MUL_OP_W-1:0]           y_reg;
    logic [MUL_PROD_W-1:0]         acc_reg;
    logic [MUL_HALF_W-1:0]         y_part;
    logic [MUL_OP_W+MUL_HALF_W-1:0] pp;

    assign y_part = phase_reg ? y_reg[MUL_OP_W-1:MUL_HALF_W] : y_reg[MUL_HALF_W-1:0];
    assign pp     = x_reg * y_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                phase_reg <= 1'b1;
                if (phase_reg)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
        end
        else if (busy_reg)
        begin
            if (phase_reg)
                acc_reg <= acc_reg + {pp, {MUL_HALF_W{1'b0}}};
            else
                acc_reg <= {{(MUL_PROD_W-MUL_OP_W-MUL_HALF_W){1'b0}}, pp};
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/mgdg_div.sv =====
// shared restoring divider, one quotient bit per cycle, msb of num first
// depends on mgdg_pkg
module mgdg_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mgdg_pkg::div_ctl_t              ctl,
    input  logic [mgdg_pkg::DIV_NUM_W-1:0]  num,
    input  logic [mgdg_pkg::DIV_DEN_W-1:0]  den,
    output logic [mgdg_pkg::DIV_NUM_W-1:0]  quo,
    output logic [mgdg_pkg::DIV_DEN_W-1:0]  rem,
    output logic                            done
);
    import mgdg_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  den_reg;
    logic [DIV_DEN_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ctl.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            num_reg <= num;
            den_reg <= den;
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
            if (fits)
                rem_reg <= DIV_DEN_W'(trial - {1'b0, den_reg});
            else
                rem_reg <= trial[DIV_DEN_W-1:0];
        end
    end

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ===== hw/rtl/mgdg_ring.sv =====
// sample ring memory, one write port and one registered read port
// depends on mgdg_pkg
module mgdg_ring (
    input  logic                          clk,
    input  logic                          we,
    input  logic [mgdg_pkg::RING_AW-1:0]  waddr,
    input  logic [mgdg_pkg::SAMPLE_W-1:0] wdata,
    input  logic                          re,
    input  logic [mgdg_pkg::RING_AW-1:0]  raddr,
    output logic [mgdg_pkg::SAMPLE_W-1:0] rdata
);
    import mgdg_pkg::*;

    logic [SAMPLE_W-1:0] mem [RING_DEPTH];
    logic [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mackey_glass_delay_generator.sv =====
// mackey-glass delay generator top: sequencer, config registers, datapath
// depends on mgdg_pkg, mgdg_mul, mgdg_div, mgdg_ring
// modes 0 and 3 complete without leaving idle; mode 1 runs an index reduction and a 56-step
// divide on the shared divider and six multiplies on the shared multiplier
// mode 2 adds a tap spacing reduction, one word per tap and one for the target, plus stalls
// one word at a time, not ready while busy; reset clears config to defaults,
// write pointer to zero, ring contents undefined until written
module mackey_glass_delay_generator
    import mgdg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COEF_W-1:0]     cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            mode,
    input  logic signed [SAMPLE_W-1:0] load_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic                  is_target,
    output logic                  last
);

    typedef enum logic [4:0] {
        S_IDLE, S_FGO, S_FWAIT, S_RD0, S_RD1, S_RD2, S_MGO, S_MWAIT,
        S_DGO, S_DWAIT, S_SGO, S_SWAIT, S_TADV, S_TRD, S_TOUT, S_TGT, S_LOUT
    } state_t;

    state_t state_reg;

    logic [COEF_W-1:0]  coef_b_reg, coef_c_reg;
    logic [RING_AW-1:0] fb_delay_reg, tap_space_reg;
    logic [TAP_W-1:0]   tap_count_reg;
    logic [LEN_W-1:0]   ring_len_reg;
    logic [RING_AW-1:0] wp_reg;
    logic               emit_reg;
    logic [2:0]         mop_reg;
    logic [TAP_W-1:0]   tap_cnt_reg;
    logic               out_valid_reg, is_target_reg, last_reg;

    logic signed [SAMPLE_W-1:0] y0_reg, yt_reg;
    logic [SAMPLE_W-1:0] bm_reg;
    logic [47:0]         n_reg;
    logic [POW_W-1:0]    a2_reg, a4_reg, a8_reg, a10_reg;
    logic [RING_AW-1:0]  fb_off_reg, sp_off_reg, idx_reg;

    logic [LEN_W-1:0]   len;
    logic [RING_AW-1:0] wp_norm;
    logic [RING_AW-1:0] wp_inc;
    logic [RING_AW-1:0] yt_addr;
    logic [RING_AW-1:0] idx_adv;
    logic [TAP_W-1:0]   taps;
    logic [SAMPLE_W-1:0] a_mag, y0_mag;
    logic               in_acc;

    logic                  mul_start, mul_done, mul_ovr;
    logic [MUL_OP_W-1:0]   mul_x, mul_y;
    logic [MUL_PROD_W-1:0] mul_prod;
    logic [POW_W-1:0]      pow_res;

    div_ctl_t              div_ctl;
    logic [DIV_NUM_W-1:0]  div_num, div_quo;
    logic [DIV_DEN_W-1:0]  div_den, div_rem;
    logic                  div_done;

    logic                       ring_we, ring_re;
    logic [RING_AW-1:0]         ring_waddr, ring_raddr;
    logic [SAMPLE_W-1:0]        ring_wdata, ring_rdata;

    logic signed [35:0]         nv;
    logic signed [SAMPLE_W-1:0] nv_sat;

    function automatic logic [RING_AW-1:0] wrap_add(
        input logic [RING_AW-1:0] p,
        input logic [RING_AW-1:0] q,
        input logic [LEN_W-1:0]   n
    );
        logic [LEN_W-1:0] s;
        s = {1'b0, p} + {1'b0, q};
        if (s >= n)
            s = s - n;
        return s[RING_AW-1:0];
    endfunction

    always_comb
    begin
        if (ring_len_reg == '0)
            len = LEN_W'(1);
        else if (ring_len_reg > LEN_W'(RING_DEPTH))
            len = LEN_W'(RING_DEPTH);
        else
            len = ring_len_reg;
    end

    assign wp_norm = ({1'b0, wp_reg} >= len) ? '0 : wp_reg;
    assign wp_inc  = wrap_add(wp_reg, RING_AW'(1), len);
    assign yt_addr = wrap_add(fb_off_reg, wp_reg, len);
    assign idx_adv = wrap_add(idx_reg, sp_off_reg, len);
    assign taps    = (tap_count_reg > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tap_count_reg;
    assign in_acc  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    assign a_mag  = yt_reg[SAMPLE_W-1] ? SAMPLE_W'(-yt_reg) : SAMPLE_W'(yt_reg);
    assign y0_mag = y0_reg[SAMPLE_W-1] ? SAMPLE_W'(-y0_reg) : SAMPLE_W'(y0_reg);

    // multiply operand select
    always_comb
    begin
        mul_x   = '0;
        mul_y   = '0;
        mul_ovr = 1'b0;
        case (mop_reg)
            3'd0:
            begin
                mul_x = MUL_OP_W'(coef_b_reg);
                mul_y = MUL_OP_W'(y0_mag);
            end
            3'd1:
            begin
                mul_x = MUL_OP_W'(a_mag);
                mul_y = MUL_OP_W'(a_mag);
            end
            3'd2:
            begin
                mul_x = MUL_OP_W'(coef_c_reg);
                mul_y = MUL_OP_W'(a_mag);
            end
            3'd3:
            begin
                mul_x = a2_reg[MUL_OP_W-1:0];
                mul_y = a2_reg[MUL_OP_W-1:0];
            end
            3'd4:
            begin
                mul_x   = a4_reg[MUL_OP_W-1:0];
                mul_y   = a4_reg[MUL_OP_W-1:0];
                mul_ovr = (a4_reg[POW_W-1:MUL_OP_W] != '0);
            end
            3'd5:
            begin
                mul_x   = a8_reg[MUL_OP_W-1:0];
                mul_y   = a2_reg[MUL_OP_W-1:0];
                mul_ovr = (a8_reg[POW_W-1:MUL_OP_W] != '0);
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign mul_start = (state_reg == S_MGO);
    assign pow_res   = (mul_ovr || mul_prod[MUL_PROD_W-1:64] != '0)
                       ? POW_CAP : POW_W'(mul_prod[63:FRAC_BITS]);

    // divider operand select
    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.steps = DIV_STEP_W'(RING_AW);
        div_num       = {fb_delay_reg, {(DIV_NUM_W-RING_AW){1'b0}}};
        div_den       = DIV_DEN_W'(len);
        case (state_reg)
            S_FGO:
            begin
                div_ctl.start = 1'b1;
            end
            S_SGO:
            begin
                div_ctl.start = 1'b1;
                div_num       = {tap_space_reg, {(DIV_NUM_W-RING_AW){1'b0}}};
            end
            S_DGO:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = DIV_STEP_W'(DIV_NUM_W);
                div_num       = {n_reg, 8'd0};
                div_den       = (DIV_DEN_W'(1) << FRAC_BITS) + DIV_DEN_W'(a10_reg);
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    // new sample: y0 - b*y0 + c*yt/(1+yt^10), saturated
    always_comb
    begin
        logic signed [35:0] by0, term;
        by0 = y0_reg[SAMPLE_W-1] ? -$signed({4'd0, bm_reg}) : $signed({4'd0, bm_reg});
        term = yt_reg[SAMPLE_W-1] ? -$signed({3'd0, div_quo[32:0]})
                                  : $signed({3'd0, div_quo[32:0]});
        nv = 36'(y0_reg) - by0 + term;
        if (nv > 36'sh0_7FFF_FFFF)
            nv_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
        else if (nv < -36'sh0_8000_0000)
            nv_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            nv_sat = nv[SAMPLE_W-1:0];
    end

    // ring access
    always_comb
    begin
        ring_we    = 1'b0;
        ring_waddr = wp_reg;
        ring_wdata = nv_sat;
        if (state_reg == S_IDLE && in_acc && mode == MODE_STORE)
        begin
            ring_we    = 1'b1;
            ring_waddr = wp_norm;
            ring_wdata = load_value;
        end
        else if (state_reg == S_DWAIT && div_done)
        begin
            ring_we = 1'b1;
        end
    end

    always_comb
    begin
        ring_re    = 1'b0;
        ring_raddr = wp_reg;
        case (state_reg)
            S_RD0: ring_re = 1'b1;
            S_RD1:
            begin
                ring_re    = 1'b1;
                ring_raddr = yt_addr;
            end
            S_TRD:
            begin
                ring_re    = 1'b1;
                ring_raddr = idx_reg;
            end
            S_TGT: ring_re = 1'b1;
            default: ring_re = 1'b0;
        endcase
    end

    mgdg_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .x     (mul_x),
        .y     (mul_y),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    mgdg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   (div_num),
        .den   (div_den),
        .quo   (div_quo),
        .rem   (div_rem),
        .done  (div_done)
    );

    mgdg_ring u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    // sequencer, config and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            coef_b_reg    <= COEF_W'(6554);
            coef_c_reg    <= COEF_W'(13107);
            fb_delay_reg  <= RING_AW'(17);
            tap_space_reg <= RING_AW'(6);
            tap_count_reg <= TAP_W'(4);
            ring_len_reg  <= LEN_W'(307);
            wp_reg        <= '0;
            emit_reg      <= 1'b0;
            mop_reg       <= '0;
            tap_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            is_target_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_COEF_B:    coef_b_reg    <= cfg_data;
                    CFG_COEF_C:    coef_c_reg    <= cfg_data;
                    CFG_FB_DELAY:  fb_delay_reg  <= cfg_data[RING_AW-1:0];
                    CFG_TAP_SPACE: tap_space_reg <= cfg_data[RING_AW-1:0];
                    CFG_TAP_COUNT: tap_count_reg <= cfg_data[TAP_W-1:0];
                    CFG_RING_LEN:  ring_len_reg  <= cfg_data[LEN_W-1:0];
                    default:       ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (mode == MODE_STORE)
                            wp_reg <= wrap_add(wp_norm, RING_AW'(1), len);
                        else if (mode == MODE_STEP || mode == MODE_EMIT)
                        begin
                            wp_reg    <= wp_norm;
                            emit_reg  <= (mode == MODE_EMIT);
                            state_reg <= S_FGO;
                        end
                    end
                end
                S_FGO:   state_reg <= S_FWAIT;
                S_FWAIT: if (div_done) state_reg <= S_RD0;
                S_RD0:   state_reg <= S_RD1;
                S_RD1:   state_reg <= S_RD2;
                S_RD2:
                begin
                    mop_reg   <= '0;
                    state_reg <= S_MGO;
                end
                S_MGO:   state_reg <= S_MWAIT;
                S_MWAIT:
                begin
                    if (mul_done)
                    begin
                        mop_reg <= mop_reg + 1'b1;
                        if (mop_reg == 3'd5)
                            state_reg <= S_DGO;
                        else
                            state_reg <= S_MGO;
                    end
                end
                S_DGO:   state_reg <= S_DWAIT;
                S_DWAIT:
                begin
                    if (div_done)
                    begin
                        wp_reg    <= wp_inc;
                        state_reg <= emit_reg ? S_SGO : S_IDLE;
                    end
                end
                S_SGO:   state_reg <= S_SWAIT;
                S_SWAIT:
                begin
                    if (div_done)
                    begin
                        tap_cnt_reg <= '0;
                        state_reg   <= (taps == '0) ? S_TGT : S_TADV;
                    end
                end
                S_TADV:  state_reg <= S_TRD;
                S_TRD:
                begin
                    out_valid_reg <= 1'b1;
                    is_target_reg <= 1'b0;
                    last_reg      <= 1'b0;
                    state_reg     <= S_TOUT;
                end
                S_TOUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        tap_cnt_reg   <= tap_cnt_reg + 1'b1;
                        state_reg     <= (tap_cnt_reg + 1'b1 == taps) ? S_TGT : S_TADV;
                    end
                end
                S_TGT:
                begin
                    out_valid_reg <= 1'b1;
                    is_target_reg <= 1'b1;
                    last_reg      <= 1'b1;
                    state_reg     <= S_LOUT;
                end
                S_LOUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_FWAIT: if (div_done) fb_off_reg <= div_rem[RING_AW-1:0];
            S_RD1:   y0_reg <= ring_rdata;
            S_RD2:   yt_reg <= ring_rdata;
            S_MWAIT:
            begin
                if (mul_done)
                begin
                    case (mop_reg)
                        3'd0: bm_reg  <= mul_prod[47:16];
                        3'd1: a2_reg  <= pow_res;
                        3'd2: n_reg   <= mul_prod[47:0];
                        3'd3: a4_reg  <= pow_res;
                        3'd4: a8_reg  <= pow_res;
                        3'd5: a10_reg <= pow_res;
                        default: ;
                    endcase
                end
            end
            S_SWAIT:
            begin
                if (div_done)
                begin
                    sp_off_reg <= div_rem[RING_AW-1:0];
                    idx_reg    <= wp_reg;
                end
            end
            S_TADV:  idx_reg <= idx_adv;
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign sample    = ring_rdata;
    assign is_target = is_target_reg;
    assign last      = last_reg;

    a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a word is pending");

    a_last_tgt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == is_target))
        else $error("last and target flag disagree");

    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == S_MWAIT)
        else $error("multiplier finished outside its wait state");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_FWAIT || state_reg == S_DWAIT || state_reg == S_SWAIT))
        else $error("divider finished outside a wait state");

endmodule
